// ===== rtl/core/drfp_pkg.sv =====
// shared types, character codes and limits for the decimal field parser
`timescale 1ns / 1ps
package drfp_pkg;

  localparam int DRFP_ACC_WIDTH = 63;
  localparam int DRFP_VAL_W     = 63;
  localparam int DRFP_EXP_W     = 14;
  localparam int DRFP_CNT_W     = 6;

  localparam logic [DRFP_EXP_W-1:0] DRFP_EXP_MAX = DRFP_EXP_W'(9999);
  localparam logic [DRFP_CNT_W-1:0] DRFP_CNT_MAX = DRFP_CNT_W'(63);

  localparam logic [2:0] CL_DIGIT = 3'd0;
  localparam logic [2:0] CL_SPACE = 3'd1;
  localparam logic [2:0] CL_MINUS = 3'd2;
  localparam logic [2:0] CL_PLUS  = 3'd3;
  localparam logic [2:0] CL_POINT = 3'd4;
  localparam logic [2:0] CL_EXPL  = 3'd5;
  localparam logic [2:0] CL_OTHER = 3'd6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_LO_D  = 8'h64;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic                  ok;
    logic                  negative;
    logic [DRFP_VAL_W-1:0] whole_value;
    logic [DRFP_VAL_W-1:0] frac_value;
    logic [DRFP_CNT_W-1:0] frac_digits;
    logic                  exp_negative;
    logic [DRFP_EXP_W-1:0] exp_value;
    logic                  overflow;
  } out_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
  } char_info_t;

endpackage

// ===== rtl/core/drfp_classify.sv =====
// character classifier: class code and digit value of one byte
`timescale 1ns / 1ps
module drfp_classify (
  input  logic [7:0]              character,
  output drfp_pkg::char_info_t    info
);
  import drfp_pkg::*;

  always_comb begin
    info.digit = character[3:0];
    priority if (character >= CH_ZERO && character <= CH_NINE) begin
      info.cls = CL_DIGIT;
    end else if (character == CH_SPACE || (character >= CH_TAB && character <= CH_CR)) begin
      info.cls = CL_SPACE;
    end else if (character == CH_MINUS) begin
      info.cls = CL_MINUS;
    end else if (character == CH_PLUS) begin
      info.cls = CL_PLUS;
    end else if (character == CH_POINT) begin
      info.cls = CL_POINT;
    end else if (character == CH_UP_E || character == CH_LO_E ||
                 character == CH_UP_D || character == CH_LO_D) begin
      info.cls = CL_EXPL;
    end else begin
      info.cls = CL_OTHER;
    end
  end

endmodule

// ===== rtl/core/drfp_parse.sv =====
// parse state registers, per-character update and result formation
`timescale 1ns / 1ps
module drfp_parse #(
  parameter int AccWidth = drfp_pkg::DRFP_ACC_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 last,
  input  drfp_pkg::char_info_t info,
  output drfp_pkg::out_t       res
);
  import drfp_pkg::*;

  localparam int SumW = AccWidth + 4;
  localparam int ExpSumW = DRFP_EXP_W + 4;

  localparam logic [3:0] PH_WAIT    = 4'd0;
  localparam logic [3:0] PH_NUMSIGN = 4'd1;
  localparam logic [3:0] PH_WHOLE   = 4'd2;
  localparam logic [3:0] PH_DOT     = 4'd3;
  localparam logic [3:0] PH_FRAC    = 4'd4;
  localparam logic [3:0] PH_EXPLET  = 4'd5;
  localparam logic [3:0] PH_EXPSIGN = 4'd6;
  localparam logic [3:0] PH_EXP     = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  logic [3:0]            phase_r, phase_nxt;
  logic                  failed_r, failed_nxt;
  logic                  sign_r, sign_nxt;
  logic [AccWidth-1:0]   whole_r, whole_nxt;
  logic [AccWidth-1:0]   frac_r, frac_nxt;
  logic [DRFP_CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic                  esign_r, esign_nxt;
  logic [DRFP_EXP_W-1:0] exp_r, exp_nxt;
  logic                  saw_whole_r, saw_whole_nxt;
  logic                  saw_frac_r, saw_frac_nxt;
  logic                  sat_r, sat_nxt;

  logic [SumW-1:0]       whole_sum, frac_sum;
  logic [ExpSumW-1:0]    exp_sum;
  logic                  whole_ovf, frac_ovf, exp_ovf, fcnt_full;
  logic [AccWidth-1:0]   whole_push, frac_push;
  logic [DRFP_EXP_W-1:0] exp_push;
  logic                  bad, good;

  // acc * 10 + digit; whole and fraction saturate at all-ones, the exponent at DRFP_EXP_MAX
  assign whole_sum = {1'b0, whole_r, 3'b000} + {3'b000, whole_r, 1'b0} + SumW'(info.digit);
  assign frac_sum  = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0} + SumW'(info.digit);
  assign exp_sum   = {1'b0, exp_r, 3'b000} + {3'b000, exp_r, 1'b0} + ExpSumW'(info.digit);

  assign whole_ovf  = |whole_sum[SumW-1:AccWidth];
  assign frac_ovf   = |frac_sum[SumW-1:AccWidth];
  assign exp_ovf    = exp_sum > ExpSumW'(DRFP_EXP_MAX);
  assign fcnt_full  = fcnt_r == DRFP_CNT_MAX;
  assign whole_push = whole_ovf ? '1 : whole_sum[AccWidth-1:0];
  assign frac_push  = frac_ovf ? '1 : frac_sum[AccWidth-1:0];
  assign exp_push   = exp_ovf ? DRFP_EXP_MAX : exp_sum[DRFP_EXP_W-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    failed_nxt    = failed_r;
    sign_nxt      = sign_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    fcnt_nxt      = fcnt_r;
    esign_nxt     = esign_r;
    exp_nxt       = exp_r;
    saw_whole_nxt = saw_whole_r;
    saw_frac_nxt  = saw_frac_r;
    sat_nxt       = sat_r;
    bad           = 1'b0;
    if (!failed_r) begin
      unique case (phase_r)
        PH_WAIT, PH_NUMSIGN: begin
          if (info.cls == CL_DIGIT) begin
            whole_nxt     = whole_push;
            sat_nxt       = sat_r | whole_ovf;
            saw_whole_nxt = 1'b1;
            phase_nxt     = PH_WHOLE;
          end else if (info.cls == CL_POINT) begin
            phase_nxt = PH_DOT;
          end else if (phase_r == PH_WAIT && info.cls == CL_SPACE) begin
            phase_nxt = PH_WAIT;
          end else if (phase_r == PH_WAIT && info.cls == CL_MINUS) begin
            sign_nxt  = 1'b1;
            phase_nxt = PH_NUMSIGN;
          end else if (phase_r == PH_WAIT && info.cls == CL_PLUS) begin
            phase_nxt = PH_NUMSIGN;
          end else begin
            bad = 1'b1;
          end
        end
        PH_WHOLE: begin
          if (info.cls == CL_DIGIT) begin
            whole_nxt = whole_push;
            sat_nxt   = sat_r | whole_ovf;
          end else if (info.cls == CL_POINT) begin
            phase_nxt = PH_DOT;
          end else begin
            bad = 1'b1;
          end
        end
        PH_DOT, PH_FRAC: begin
          if (info.cls == CL_DIGIT) begin
            frac_nxt     = frac_push;
            sat_nxt      = sat_r | frac_ovf | fcnt_full;
            fcnt_nxt     = fcnt_full ? fcnt_r : fcnt_r + DRFP_CNT_W'(1);
            saw_frac_nxt = 1'b1;
            phase_nxt    = PH_FRAC;
          end else if (info.cls == CL_SPACE) begin
            phase_nxt = PH_DONE;
          end else if (info.cls == CL_EXPL) begin
            phase_nxt = PH_EXPLET;
          end else begin
            bad = 1'b1;
          end
        end
        PH_EXPLET: begin
          if (info.cls == CL_MINUS) begin
            esign_nxt = 1'b1;
            phase_nxt = PH_EXPSIGN;
          end else if (info.cls == CL_PLUS) begin
            phase_nxt = PH_EXPSIGN;
          end else if (info.cls == CL_DIGIT) begin
            exp_nxt   = exp_push;
            sat_nxt   = sat_r | exp_ovf;
            phase_nxt = PH_EXP;
          end else begin
            bad = 1'b1;
          end
        end
        PH_EXPSIGN: begin
          if (info.cls == CL_DIGIT) begin
            exp_nxt   = exp_push;
            sat_nxt   = sat_r | exp_ovf;
            phase_nxt = PH_EXP;
          end else begin
            bad = 1'b1;
          end
        end
        PH_EXP: begin
          if (info.cls == CL_DIGIT) begin
            exp_nxt = exp_push;
            sat_nxt = sat_r | exp_ovf;
          end else if (info.cls == CL_SPACE) begin
            phase_nxt = PH_DONE;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          // trailing whitespace only
          bad = info.cls != CL_SPACE;
        end
      endcase
    end
    failed_nxt = failed_r | bad;
  end

  always_comb begin
    good             = !failed_nxt && (saw_whole_nxt || saw_frac_nxt);
    res.ok           = good;
    res.negative     = good & sign_nxt;
    res.whole_value  = good ? DRFP_VAL_W'(whole_nxt) : '0;
    res.frac_value   = good ? DRFP_VAL_W'(frac_nxt) : '0;
    res.frac_digits  = good ? fcnt_nxt : '0;
    res.exp_negative = good & esign_nxt;
    res.exp_value    = good ? exp_nxt : '0;
    res.overflow     = good & sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r     <= PH_WAIT;
      failed_r    <= 1'b0;
      sign_r      <= 1'b0;
      whole_r     <= '0;
      frac_r      <= '0;
      fcnt_r      <= '0;
      esign_r     <= 1'b0;
      exp_r       <= '0;
      saw_whole_r <= 1'b0;
      saw_frac_r  <= 1'b0;
      sat_r       <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      failed_r    <= failed_nxt;
      sign_r      <= sign_nxt;
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      fcnt_r      <= fcnt_nxt;
      esign_r     <= esign_nxt;
      exp_r       <= exp_nxt;
      saw_whole_r <= saw_whole_nxt;
      saw_frac_r  <= saw_frac_nxt;
      sat_r       <= sat_nxt;
    end
  end

endmodule

// ===== rtl/core/decimal_real_field_parser_top.sv =====
// top level of the decimal field parser: input register, parse step, result register
//
//  channel  ports                          item
//  input    in_valid  in_ready  in_data    one character and its last-character mark
//  result   out_valid out_ready out_data   one parsed field, given on its last character
//
// one character per cycle, save that a last character waits for a full result register;
// an item waits in the input register; its result, if any, is registered in the result
// register; the loop that sets the rate is the state update (multiply by ten, add)
// reset (rst_n low at a clock edge) empties both registers and clears the parse state
// a stalled result holds only a last character; other characters keep flowing
`timescale 1ns / 1ps
module decimal_real_field_parser_top #(
  parameter int AccWidth = drfp_pkg::DRFP_ACC_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  drfp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output drfp_pkg::out_t out_data
);
  import drfp_pkg::*;

  in_t        in_r;
  logic       in_vld_r, in_vld_nxt;
  out_t       out_r;
  logic       out_vld_r, out_vld_nxt;
  logic       out_free, step;
  char_info_t info;
  out_t       res;

  assign out_free   = !out_vld_r || out_ready;
  assign step       = in_vld_r && (!in_r.last_char || out_free);
  assign in_ready   = !in_vld_r || step;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !step);
  assign out_vld_nxt = (step && in_r.last_char) || (out_vld_r && !out_ready);

  drfp_classify u_classify (
    .character (in_r.character),
    .info      (info)
  );

  drfp_parse #(
    .AccWidth (AccWidth)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .last  (in_r.last_char),
    .info  (info),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (step && in_r.last_char) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/drfp_checker.sv =====
// port-level checker for the decimal field parser and its bind
`timescale 1ns / 1ps
module drfp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input drfp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input drfp_pkg::out_t out_data
);
  import drfp_pkg::*;

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a failed field carries nothing but zeros
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |->
      !out_data.negative && out_data.whole_value == '0 && out_data.frac_value == '0 &&
      out_data.frac_digits == '0 && !out_data.exp_negative &&
      out_data.exp_value == '0 && !out_data.overflow)
    else $error("failed field with non-zero content");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.exp_value <= DRFP_EXP_MAX)
    else $error("exponent beyond its limit");

  // no fraction digits means no fraction value
  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frac_digits == '0 |-> out_data.frac_value == '0)
    else $error("fraction value without fraction digits");

  // input side never stalls while the result register is empty
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind decimal_real_field_parser_top drfp_checker u_drfp_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench for the decimal field parser: directed table, then random fields
`timescale 1ns / 1ps
module tb;
  import drfp_pkg::*;

  typedef enum logic [3:0] {
    PH_WAIT, PH_SIGN, PH_WHOLE, PH_POINT, PH_FRAC, PH_EXP_LETTER, PH_EXP_SIGN, PH_EXP, PH_TAIL
  } phase_e;

  typedef struct {
    in_t  item;
    bit   pinned;
    out_t want;
  } row_t;

  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF >> (63 - DRFP_ACC_WIDTH);
  localparam int          LIVE_ITEMS = 1450;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  bit   cur_pinned;
  out_t cur_want;
  bit   calm;

  out_t       fields_due[$];
  logic [7:0] field_text[$];
  int         mismatches;
  int         live_items;

  phase_e                fld_phase;
  logic                  fld_failed;
  logic                  fld_minus;
  logic                  fld_exp_minus;
  logic                  fld_saw_whole;
  logic                  fld_saw_frac;
  logic                  fld_sat;
  logic [63:0]           fld_whole;
  logic [63:0]           fld_frac;
  logic [DRFP_CNT_W-1:0] fld_frac_cnt;
  logic [DRFP_EXP_W-1:0] fld_exp;

  decimal_real_field_parser_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic clear_field();
    fld_phase     = PH_WAIT;
    fld_failed    = 1'b0;
    fld_minus     = 1'b0;
    fld_exp_minus = 1'b0;
    fld_saw_whole = 1'b0;
    fld_saw_frac  = 1'b0;
    fld_sat       = 1'b0;
    fld_whole     = '0;
    fld_frac      = '0;
    fld_frac_cnt  = '0;
    fld_exp       = '0;
  endtask

  function automatic logic [2:0] char_class(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return CL_DIGIT;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CL_SPACE;
    if (c == CH_MINUS) return CL_MINUS;
    if (c == CH_PLUS) return CL_PLUS;
    if (c == CH_POINT) return CL_POINT;
    if (c == CH_UP_E || c == CH_LO_E || c == CH_UP_D || c == CH_LO_D) return CL_EXPL;
    return CL_OTHER;
  endfunction

  function automatic logic [63:0] acc_push(logic [63:0] acc, logic [3:0] d);
    if (acc > (ACC_MAX - 64'(d)) / 64'd10) begin
      fld_sat = 1'b1;
      return ACC_MAX;
    end
    return acc * 64'd10 + 64'(d);
  endfunction

  task automatic exp_push(logic [3:0] d);
    int cur;
    cur = int'(fld_exp);
    if (cur > (int'(DRFP_EXP_MAX) - int'(d)) / 10) begin
      fld_sat = 1'b1;
      fld_exp = DRFP_EXP_MAX;
    end else begin
      fld_exp = DRFP_EXP_W'(cur * 10 + int'(d));
    end
    fld_phase = PH_EXP;
  endtask

  task automatic frac_push(logic [3:0] d);
    fld_frac = acc_push(fld_frac, d);
    if (fld_frac_cnt >= DRFP_CNT_MAX) fld_sat = 1'b1;
    else fld_frac_cnt = fld_frac_cnt + 1'b1;
    fld_saw_frac = 1'b1;
    fld_phase    = PH_FRAC;
  endtask

  task automatic whole_push(logic [3:0] d);
    fld_whole     = acc_push(fld_whole, d);
    fld_saw_whole = 1'b1;
    fld_phase     = PH_WHOLE;
  endtask

  task automatic parse_char(input in_t item, output bit has_res, output out_t res);
    logic [2:0] cls;
    logic [3:0] d;
    logic       bad;
    logic       good;
    cls     = char_class(item.character);
    d       = item.character[3:0];
    bad     = 1'b0;
    has_res = 1'b0;
    res     = '0;
    if (!fld_failed) begin
      case (fld_phase)
        PH_WAIT: begin
          if (cls == CL_MINUS) begin
            fld_minus = 1'b1;
            fld_phase = PH_SIGN;
          end else if (cls == CL_PLUS) fld_phase = PH_SIGN;
          else if (cls == CL_DIGIT) whole_push(d);
          else if (cls == CL_POINT) fld_phase = PH_POINT;
          else if (cls != CL_SPACE) bad = 1'b1;
        end
        PH_SIGN, PH_WHOLE: begin
          if (cls == CL_DIGIT) whole_push(d);
          else if (cls == CL_POINT) fld_phase = PH_POINT;
          else bad = 1'b1;
        end
        PH_POINT, PH_FRAC: begin
          if (cls == CL_DIGIT) frac_push(d);
          else if (cls == CL_SPACE) fld_phase = PH_TAIL;
          else if (cls == CL_EXPL) fld_phase = PH_EXP_LETTER;
          else bad = 1'b1;
        end
        PH_EXP_LETTER: begin
          if (cls == CL_MINUS) begin
            fld_exp_minus = 1'b1;
            fld_phase     = PH_EXP_SIGN;
          end else if (cls == CL_PLUS) fld_phase = PH_EXP_SIGN;
          else if (cls == CL_DIGIT) exp_push(d);
          else bad = 1'b1;
        end
        PH_EXP_SIGN: begin
          if (cls == CL_DIGIT) exp_push(d);
          else bad = 1'b1;
        end
        PH_EXP: begin
          if (cls == CL_DIGIT) exp_push(d);
          else if (cls == CL_SPACE) fld_phase = PH_TAIL;
          else bad = 1'b1;
        end
        default: begin
          if (cls != CL_SPACE) bad = 1'b1;
        end
      endcase
      if (bad) fld_failed = 1'b1;
    end
    if (item.last_char) begin
      has_res = 1'b1;
      good    = !fld_failed && (fld_saw_whole || fld_saw_frac);
      if (good) begin
        res.ok           = 1'b1;
        res.negative     = fld_minus;
        res.whole_value  = fld_whole[DRFP_VAL_W-1:0];
        res.frac_value   = fld_frac[DRFP_VAL_W-1:0];
        res.frac_digits  = fld_frac_cnt;
        res.exp_negative = fld_exp_minus;
        res.exp_value    = fld_exp;
        res.overflow     = fld_sat;
      end
      clear_field();
    end
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  task automatic compare_result(out_t got, out_t want);
    check_field("ok", 64'(got.ok), 64'(want.ok));
    check_field("negative", 64'(got.negative), 64'(want.negative));
    check_field("whole_value", 64'(got.whole_value), 64'(want.whole_value));
    check_field("frac_value", 64'(got.frac_value), 64'(want.frac_value));
    check_field("frac_digits", 64'(got.frac_digits), 64'(want.frac_digits));
    check_field("exp_negative", 64'(got.exp_negative), 64'(want.exp_negative));
    check_field("exp_value", 64'(got.exp_value), 64'(want.exp_value));
    check_field("overflow", 64'(got.overflow), 64'(want.overflow));
  endtask

  always @(posedge clk) begin : watch
    bit   has_res;
    out_t res;
    if (!rst_n) begin
      clear_field();
    end else begin
      if (in_valid && in_ready) begin
        live_items++;
        parse_char(in_data, has_res, res);
        if (has_res) fields_due.push_back(cur_pinned ? cur_want : res);
      end
      if (out_valid && out_ready) begin
        if (fields_due.size() == 0) flag_mismatch("result with none due", '0, '0);
        else compare_result(out_data, fields_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  task automatic send_char(in_t item, bit pinned, out_t want);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data    <= item;
    cur_pinned <= pinned;
    cur_want   <= want;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic row_t row(logic [7:0] c, logic last, bit pinned = 1'b0, logic ok = 1'b0,
                               logic [DRFP_VAL_W-1:0] whole = '0);
    row_t r;
    r.item.character   = c;
    r.item.last_char   = last;
    r.pinned           = pinned;
    r.want             = '0;
    r.want.ok          = ok;
    r.want.whole_value = whole;
    return r;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  task automatic push_digits(int n);
    repeat (n) field_text.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // mostly well-formed fields with random content, some noise and some corrupted
  task automatic make_field();
    int  mode;
    int  r;
    bit  point;
    bit  expo;
    mode = $urandom_range(99);
    field_text = {};
    if (mode < 12) begin
      repeat ($urandom_range(6, 1)) field_text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(2)) field_text.push_back(blank_char());
      r = $urandom_range(2);
      if (r == 1) field_text.push_back(CH_MINUS);
      else if (r == 2) field_text.push_back(CH_PLUS);
      push_digits(($urandom_range(99) < 4) ? $urandom_range(22, 18) : $urandom_range(4));
      point = $urandom_range(99) < 75;
      if (point) begin
        field_text.push_back(CH_POINT);
        r = $urandom_range(99);
        if (r < 3) push_digits($urandom_range(66, 60));
        else if (r < 5) push_digits($urandom_range(22, 18));
        else push_digits($urandom_range(4));
      end
      expo = (point && $urandom_range(99) < 40) || $urandom_range(99) < 4;
      if (expo) begin
        r = $urandom_range(3);
        field_text.push_back(r == 0 ? CH_UP_E : r == 1 ? CH_LO_E : r == 2 ? CH_UP_D : CH_LO_D);
        r = $urandom_range(2);
        if (r == 1) field_text.push_back(CH_MINUS);
        else if (r == 2) field_text.push_back(CH_PLUS);
        push_digits(($urandom_range(99) < 10) ? $urandom_range(6, 4) : $urandom_range(3));
      end
      if (point || $urandom_range(99) < 10) begin
        repeat ($urandom_range(2)) field_text.push_back(blank_char());
      end
      if (field_text.size() == 0) field_text.push_back(CH_ZERO);
      if (mode < 24) field_text[$urandom_range(field_text.size() - 1)] = 8'($urandom);
    end
  endtask

  initial begin : stimulus
    row_t dir_rows [0:24];
    in_t  item;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cur_pinned = 1'b0;
    cur_want   = '0;
    calm       = 1'b0;
    mismatches = 0;
    live_items = 0;
    dir_rows = '{
      row(CH_ZERO + 8'd7, 1'b1, 1'b1, 1'b1, 63'd7),
      row(8'hFF, 1'b1, 1'b1),
      row(8'h00, 1'b1, 1'b1),
      // point alone has no digits
      row(CH_POINT, 1'b1, 1'b1),
      // space after integer digits
      row(CH_SPACE, 1'b0),
      row(CH_MINUS, 1'b0),
      row(CH_ZERO + 8'd1, 1'b0),
      row(CH_SPACE, 1'b1, 1'b1),
      // exponent letter with no point fails the field
      row(CH_ZERO + 8'd1, 1'b0),
      row(CH_LO_E, 1'b0),
      row(CH_ZERO + 8'd5, 1'b1, 1'b1),
      // digits straight after the letter
      row(CH_TAB, 1'b0),
      row(CH_PLUS, 1'b0),
      row(CH_POINT, 1'b0),
      row(CH_ZERO + 8'd5, 1'b0),
      row(CH_UP_D, 1'b0),
      row(CH_ZERO + 8'd7, 1'b1),
      // field ends on the letter
      row(CH_ZERO + 8'd2, 1'b0),
      row(CH_POINT, 1'b0),
      row(CH_LO_E, 1'b1),
      // field ends on the exponent sign
      row(CH_MINUS, 1'b0),
      row(CH_POINT, 1'b0),
      row(CH_NINE, 1'b0),
      row(CH_LO_D, 1'b0),
      row(CH_MINUS, 1'b1)
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_char(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
    while (live_items < LIVE_ITEMS) begin
      make_field();
      calm <= (live_items >= 500 && live_items < 800);
      foreach (field_text[i]) begin
        item.character = field_text[i];
        item.last_char = (i == field_text.size() - 1);
        send_char(item, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
